/* rtl/core/dcbc_pkg.sv */
// Package: DES tables, permutation functions and controller types for the CBC unit.
`default_nettype none
package dcbc_pkg;

   localparam int unsigned Rounds = 16;
   localparam int unsigned HalfKeyBits = 28;
   localparam int unsigned SubkeyBits = 48;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ROUND = 2'd1,
      ST_DONE  = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      CSR_KEY = 2'd0,
      CSR_IV  = 2'd1,
      CSR_DIR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_round;
   } status_type;

   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [7:0] t [64];
      logic [63:0] r;
      t = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
            62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
            57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
            61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
      for (int i = 0; i < 64; i++) r[63-i] = v[64-t[i]];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [7:0] t [64];
      logic [63:0] r;
      t = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
            38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
            36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
            34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
      for (int i = 0; i < 64; i++) r[63-i] = v[64-t[i]];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [7:0] t [56];
      logic [55:0] r;
      t = '{57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
            10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
            63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
            14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
      for (int i = 0; i < 56; i++) r[55-i] = v[64-t[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [7:0] t [48];
      logic [47:0] r;
      t = '{14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
            41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
      for (int i = 0; i < 48; i++) r[47-i] = v[56-t[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_e(input logic [31:0] v);
      logic [7:0] t [48];
      logic [47:0] r;
      t = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
            16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
      for (int i = 0; i < 48; i++) r[47-i] = v[32-t[i]];
      return r;
   endfunction

   function automatic logic [31:0] perm_p(input logic [31:0] v);
      logic [7:0] t [32];
      logic [31:0] r;
      t = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
            2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
      for (int i = 0; i < 32; i++) r[31-i] = v[32-t[i]];
      return r;
   endfunction

   function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] six);
      logic [3:0] s [8][64];
      logic [5:0] idx;
      s = '{
 '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
   4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
 '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
   0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
 '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
   13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
 '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
   10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
 '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
   4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
 '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
   9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
 '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
   1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
 '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
   7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};
      idx = {six[5], six[0], six[4:1]};
      return s[n][idx];
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      x = perm_e(r) ^ k;
      for (int i = 0; i < 8; i++) s[31-4*i -: 4] = sbox(3'(i), x[47-6*i -: 6]);
      return perm_p(s);
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] k);
      return (k == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
   endfunction

   function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] k);
      return (k == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
   endfunction

   // left-rotate amount for round n (0-based)
   function automatic logic [1:0] rot_amt(input logic [3:0] n);
      return (n == 4'd0 || n == 4'd1 || n == 4'd8 || n == 4'd15) ? 2'd1 : 2'd2;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/dcbc_ctrl.sv */
// Controller: sequences load, sixteen rounds and result hand-off.
`default_nettype none
module dcbc_ctrl
   import dcbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // new word may enter while the last result is still waiting
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.step = 1'b1;
            if (status.last_round) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> req_stall) else $error("word accepted mid-rounds");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without valid");
endmodule
`default_nettype wire

/* rtl/core/dcbc_datapath.sv */
// Datapath: key schedule, shared round unit, CBC chaining and result register.
`default_nettype none
module dcbc_datapath
   import dcbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire logic [63:0] req_data_block,
   input  wire logic        req_start_of_message,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic [63:0]      rsp_result_block
);
   logic [63:0] key_ff, iv_ff, chain_ff, data_ff, res_ff;
   logic        dir_ff;
   logic [27:0] c_ff, d_ff, c_in, d_in, c_rot, d_rot;
   logic [31:0] l_ff, r_ff;
   logic [3:0]  rnd_ff;
   logic [55:0] cd0;
   logic [63:0] chain_sel, blk_in, ip_out, fp_out, des_res;
   logic [1:0]  amt;

   assign cd0       = perm_pc1(key_ff);
   assign chain_sel = req_start_of_message ? iv_ff : chain_ff;
   assign blk_in    = dir_ff ? req_data_block : (req_data_block ^ chain_sel);
   assign ip_out    = perm_ip(blk_in);
   assign amt       = rot_amt(rnd_ff);
   // decrypt uses the key halves as they are, then rotates right; encrypt rotates left before use
   assign c_rot     = dir_ff ? c_ff : rotl28(c_ff, amt);
   assign d_rot     = dir_ff ? d_ff : rotl28(d_ff, amt);
   assign c_in      = dir_ff ? rotr28(c_ff, rot_amt(4'(15 - rnd_ff))) : c_rot;
   assign d_in      = dir_ff ? rotr28(d_ff, rot_amt(4'(15 - rnd_ff))) : d_rot;
   assign fp_out    = perm_fp({r_ff, l_ff});
   assign des_res   = dir_ff ? (fp_out ^ chain_ff) : fp_out;
   assign status.last_round = (rnd_ff == 4'(Rounds - 1));
   assign rsp_result_block  = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         iv_ff    <= '0;
         dir_ff   <= 1'b0;
         chain_ff <= '0;
         rnd_ff   <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KEY: key_ff <= csr_data;
               CSR_IV:  iv_ff  <= csr_data;
               CSR_DIR: dir_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            rnd_ff   <= '0;
            chain_ff <= chain_sel;
         end else if (cmd.step) begin
            rnd_ff <= rnd_ff + 4'd1;
         end
         if (cmd.finish) chain_ff <= dir_ff ? data_ff : fp_out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         data_ff <= req_data_block;
         l_ff    <= ip_out[63:32];
         r_ff    <= ip_out[31:0];
         c_ff    <= cd0[55:28];
         d_ff    <= cd0[27:0];
      end else if (cmd.step) begin
         l_ff <= r_ff;
         r_ff <= l_ff ^ round_f(r_ff, perm_pc2({c_rot, d_rot}));
         c_ff <= c_in;
         d_ff <= d_in;
      end
      if (cmd.finish) res_ff <= des_res;
   end

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step)) else $error("load and step together");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.step && status.last_round |=> !cmd.step) else $error("extra round");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rnd_ff == 4'd0) else $error("round count not cleared");
endmodule
`default_nettype wire

/* rtl/core/des_cbc_block_cipher_unit.sv */
// Top level: DES-CBC block cipher unit, controller plus datapath.
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_data_block, req_start_of_message
//  rsp     | out | rsp_valid, rsp_stall, rsp_result_block
//  csr     | in  | csr_write, csr_index, csr_data
// A word passes through one load, sixteen rounds of the shared round unit and one finish.
// The key schedule rotates in step with the rounds, so no subkey storage is needed.
// Synchronous reset clears key, IV, direction and chain value to zero.
// A stalled result is held; the next word may start while it waits.
`default_nettype none
module des_cbc_block_cipher_unit
   import dcbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_data_block,
   input  wire logic        req_start_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_result_block,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   cmd_type    cmd;
   status_type status;

   dcbc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   dcbc_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_data_block, .req_start_of_message, .cmd, .status, .rsp_result_block
   );
endmodule
`default_nettype wire
